// ===== hw/rtl/iss_pkg.sv =====
// Shared types and codes for the indexed sequence store.
`default_nettype none
package iss_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DATA_W       = 32;

  typedef enum logic [3:0] {
    ACT_PUSH_BACK  = 4'd0,
    ACT_PUSH_FRONT = 4'd1,
    ACT_POP_BACK   = 4'd2,
    ACT_POP_FRONT  = 4'd3,
    ACT_INSERT     = 4'd4,
    ACT_READ       = 4'd5,
    ACT_REMOVE     = 4'd6,
    ACT_OVERWRITE  = 4'd7,
    ACT_CLEAR      = 4'd8,
    ACT_REVERSE    = 4'd9
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Per-cell command broadcast along the chain.
  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] data;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'b01,
    S_REVERSE = 2'b10
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/iss_cell.sv =====
// One storage cell of the chain: holds, loads, or takes a neighbor's value.
`default_nettype none
module iss_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire                       clk,
  input  iss_pkg::cell_ctrl_t       ctrl,
  input  wire  [CNT_W-1:0]          lo,
  input  wire  [CNT_W-1:0]          hi,
  input  wire  [iss_pkg::DATA_W-1:0] left_val,
  input  wire  [iss_pkg::DATA_W-1:0] right_val,
  output logic [iss_pkg::DATA_W-1:0] val
);
  import iss_pkg::*;

  localparam logic [CNT_W-1:0] MY = CNT_W'(IDX);

  logic [DATA_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctrl.cmd)
      CMD_OPEN: begin
        if (MY == lo) begin
          val_next = ctrl.data;
        end else if (MY > lo && MY <= hi) begin
          val_next = left_val;
        end
      end
      CMD_CLOSE: begin
        if (MY >= lo && MY < hi) begin
          val_next = right_val;
        end
      end
      CMD_WRITE: begin
        if (MY == lo) begin
          val_next = ctrl.data;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/iss_chain.sv =====
// Row of cells with neighbor links and an indexed read port.
`default_nettype none
module iss_chain #(
  parameter int CAPACITY = iss_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  wire                        clk,
  input  iss_pkg::cell_ctrl_t        ctrl,
  input  wire  [CNT_W-1:0]           lo,
  input  wire  [CNT_W-1:0]           hi,
  input  wire  [IDX_W-1:0]           sel,
  output logic [iss_pkg::DATA_W-1:0] sel_val
);
  import iss_pkg::*;

  logic [DATA_W-1:0] vals [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] lv;
    logic [DATA_W-1:0] rv;
    if (i == 0) begin : g_first
      assign lv = '0;
    end else begin : g_left
      assign lv = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = '0;
    end else begin : g_right
      assign rv = vals[i+1];
    end
    iss_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .lo        (lo),
      .hi        (hi),
      .left_val  (lv),
      .right_val (rv),
      .val       (vals[i])
    );
  end

  assign sel_val = vals[sel];

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_sequence_store_core.sv =====
// Indexed sequence store: a bounded deque of signed words with indexed access.
// Input channel (in_valid/in_stall): action, position, item_value. One
// operation is taken per transfer; the result is registered and offered on
// the output channel (out_valid/out_stall) in the cycle after the transfer.
// Result: read_value (nonzero only for a successful read), element_count
// after the operation, status (ok, full, empty, position out of range).
// Push, pop, insert, remove, overwrite, read and clear complete at once: every
// cell of the chain shifts, loads or holds in parallel under one broadcast
// command. Reverse, for count of two or more, runs in the reverse state: the
// chain moves the last element in front of position k once per cycle, for k
// from 0 up to count - 2, one insert step per element.
// A new item can be taken while an earlier result waits, as long as no
// reverse is running and the output register is free or being drained.
// When the receiver stalls, the result holds and in_stall rises once a
// second result would have nowhere to go.
// Reset (rst, synchronous) empties the store and drops any pending result;
// cell contents are not cleared and are never read before being written.
`default_nettype none
module indexed_sequence_store_core #(
  parameter int CAPACITY = iss_pkg::DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [3:0]                        action,
  input  wire  [CNT_W-1:0]                  position,
  input  wire  signed [iss_pkg::DATA_W-1:0] item_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [iss_pkg::DATA_W-1:0] read_value,
  output logic [CNT_W-1:0]                  element_count,
  output logic [1:0]                        status
);
  import iss_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO = CNT_W'(2);

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  rev_k, rev_k_next;
  cell_ctrl_t        ctrl;
  logic [CNT_W-1:0]  lo, hi;
  logic [IDX_W-1:0]  sel;
  logic [DATA_W-1:0] sel_val;
  logic              accept;
  status_t           st;
  logic [DATA_W-1:0] rd;
  logic              full, empty, idx_bad, ins_bad;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign full    = (count == CAP);
  assign empty   = (count == '0);
  assign idx_bad = (position >= count);
  assign ins_bad = (position > count);

  always_comb begin
    sel = (state == S_REVERSE) ? IDX_W'(count - ONE) : position[IDX_W-1:0];
  end

  iss_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_chain (
    .clk     (clk),
    .ctrl    (ctrl),
    .lo      (lo),
    .hi      (hi),
    .sel     (sel),
    .sel_val (sel_val)
  );

  always_comb begin
    ctrl.cmd   = CMD_HOLD;
    ctrl.data  = item_value;
    lo         = '0;
    hi         = '0;
    st         = ST_OK;
    rd         = '0;
    count_next = count;
    state_next = state;
    rev_k_next = rev_k;
    if (state == S_REVERSE) begin
      // move the tail element in front of position k
      ctrl.cmd  = CMD_OPEN;
      ctrl.data = sel_val;
      lo        = rev_k;
      hi        = count - ONE;
      rev_k_next = rev_k + ONE;
      if (rev_k == count - TWO) begin
        state_next = S_IDLE;
      end
    end else if (accept) begin
      case (action)
        ACT_PUSH_BACK: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            ctrl.cmd   = CMD_WRITE;
            lo         = count;
            count_next = count + ONE;
          end
        end
        ACT_PUSH_FRONT: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            ctrl.cmd   = CMD_OPEN;
            hi         = count;
            count_next = count + ONE;
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            count_next = count - ONE;
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            ctrl.cmd   = CMD_CLOSE;
            hi         = count - ONE;
            count_next = count - ONE;
          end
        end
        ACT_INSERT: begin
          if (full) begin
            st = ST_FULL;
          end else if (ins_bad) begin
            st = ST_RANGE;
          end else begin
            ctrl.cmd   = CMD_OPEN;
            lo         = position;
            hi         = count;
            count_next = count + ONE;
          end
        end
        ACT_READ: begin
          if (empty) begin
            st = ST_EMPTY;
          end else if (idx_bad) begin
            st = ST_RANGE;
          end else begin
            rd = sel_val;
          end
        end
        ACT_REMOVE: begin
          if (empty) begin
            st = ST_EMPTY;
          end else if (idx_bad) begin
            st = ST_RANGE;
          end else begin
            ctrl.cmd   = CMD_CLOSE;
            lo         = position;
            hi         = count - ONE;
            count_next = count - ONE;
          end
        end
        ACT_OVERWRITE: begin
          if (empty) begin
            st = ST_EMPTY;
          end else if (idx_bad) begin
            st = ST_RANGE;
          end else begin
            ctrl.cmd = CMD_WRITE;
            lo       = position;
          end
        end
        ACT_CLEAR: begin
          count_next = '0;
        end
        ACT_REVERSE: begin
          if (count >= TWO) begin
            state_next = S_REVERSE;
            rev_k_next = '0;
          end
        end
        default: st = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rev_k <= rev_k_next;
    if (accept) begin
      read_value    <= rd;
      element_count <= count_next;
      status        <= st;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_indexed_sequence_store_core.sv =====
// Testbench for the indexed sequence store core: directed and random list operations.
`timescale 1ns / 100ps
`default_nettype none
module tb_indexed_sequence_store_core;
  import iss_pkg::*;

  localparam int CAP   = DEF_CAPACITY;
  localparam int CNT_W = $clog2(DEF_CAPACITY + 1);
  localparam logic [3:0] ACT_UNUSED_FIRST = 4'd10;
  localparam logic [3:0] ACT_UNUSED_LAST  = 4'd15;
  localparam int RANDOM_OPS = 1450;

  typedef struct {
    logic signed [DATA_W-1:0] rd;
    logic [CNT_W-1:0]         cnt;
    status_t                  st;
  } outcome_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [3:0]               action = '0;
  logic [CNT_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] item_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic [CNT_W-1:0]         element_count;
  logic [1:0]               status;

  logic signed [DATA_W-1:0] shadow_q[$];
  outcome_t                 expected_q[$];
  int                       fail_count = 0;
  int                       burst_left = 0;
  int                       random_sent = 0;

  indexed_sequence_store_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .position      (position),
    .item_value    (item_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_value    (read_value),
    .element_count (element_count),
    .status        (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Apply one operation to the shadow sequence and return the result it yields.
  function automatic outcome_t apply_op(logic [3:0] act, logic [CNT_W-1:0] pos,
                                        logic signed [DATA_W-1:0] val);
    outcome_t r;
    int n;
    logic signed [DATA_W-1:0] flipped[$];
    n = shadow_q.size();
    r.rd = '0;
    r.st = ST_OK;
    case (act)
      ACT_PUSH_BACK: begin
        if (n >= CAP) r.st = ST_FULL;
        else shadow_q.insert(n, val);
      end
      ACT_PUSH_FRONT: begin
        if (n >= CAP) r.st = ST_FULL;
        else shadow_q.insert(0, val);
      end
      ACT_POP_BACK: begin
        if (n == 0) r.st = ST_EMPTY;
        else shadow_q.delete(n - 1);
      end
      ACT_POP_FRONT: begin
        if (n == 0) r.st = ST_EMPTY;
        else shadow_q.delete(0);
      end
      ACT_INSERT: begin
        if (n >= CAP) r.st = ST_FULL;
        else if (int'(pos) > n) r.st = ST_RANGE;
        else shadow_q.insert(int'(pos), val);
      end
      ACT_READ, ACT_REMOVE, ACT_OVERWRITE: begin
        if (n == 0) r.st = ST_EMPTY;
        else if (int'(pos) >= n) r.st = ST_RANGE;
        else if (act == ACT_READ) r.rd = shadow_q[pos];
        else if (act == ACT_REMOVE) shadow_q.delete(int'(pos));
        else shadow_q[pos] = val;
      end
      ACT_CLEAR: shadow_q.delete();
      ACT_REVERSE: begin
        foreach (shadow_q[i]) flipped.insert(0, shadow_q[i]);
        shadow_q = flipped;
      end
      default: ;
    endcase
    r.cnt = CNT_W'(shadow_q.size());
    return r;
  endfunction

  function automatic void note_failure(string msg);
    if (fail_count < 10) $display("MISMATCH %0t: %s", $realtime, msg);
    fail_count++;
  endfunction

  // Predict on every input transfer, check every output transfer.
  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result rd=%0d cnt=%0d st=%0d",
                                 read_value, element_count, status));
        end else begin
          exp_r = expected_q[0];
          expected_q.delete(0);
          if (read_value !== exp_r.rd || element_count !== exp_r.cnt ||
              status !== exp_r.st)
            note_failure($sformatf("expected rd=%0d cnt=%0d st=%0d, got rd=%0d cnt=%0d st=%0d",
                                   exp_r.rd, exp_r.cnt, exp_r.st,
                                   read_value, element_count, status));
        end
      end
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(), apply_op(action, position, item_value));
    end
  end

  // Receiver stall pattern: switch between modes every so often.
  int stall_mode = 0;
  int stall_span = 100;
  int stall_tick = 0;
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(50, 300);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 5) < 3;
    endcase
  end

  // Send one item; the sender works in bursts with random gaps between them.
  task automatic send_op(input logic [3:0] act, input logic [CNT_W-1:0] pos,
                         input logic signed [DATA_W-1:0] val);
    int gap;
    if (burst_left == 0) burst_left = $urandom_range(1, 16);
    in_valid   <= 1'b1;
    action     <= act;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      // Drop valid only for a real gap, so it is not lowered and raised in one step.
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [CNT_W-1:0] pick_position(int upper);
    if ($urandom_range(0, 4) == 0) return CNT_W'($urandom_range(0, 2**CNT_W - 1));
    return CNT_W'($urandom_range(0, upper));
  endfunction

  task automatic test_empty_store();
    send_op(ACT_POP_BACK, '0, 32'sd5);
    send_op(ACT_POP_FRONT, '0, 32'sd6);
    send_op(ACT_READ, '0, '0);
    send_op(ACT_REMOVE, '0, '0);
    send_op(ACT_OVERWRITE, '0, 32'sd9);
    send_op(ACT_REVERSE, '0, '0);
    send_op(ACT_CLEAR, '0, '0);
    send_op(ACT_INSERT, 7'd1, 32'sd3);
    send_op(ACT_UNUSED_LAST, 7'd127, -32'sd1);
  endtask

  task automatic test_single_element();
    // Insert at the end of an empty store appends.
    send_op(ACT_INSERT, '0, 32'sh7FFF_FFFF);
    send_op(ACT_READ, '0, '0);
    send_op(ACT_OVERWRITE, '0, 32'sh8000_0000);
    send_op(ACT_READ, '0, '0);
    send_op(ACT_POP_FRONT, '0, '0);
    send_op(ACT_PUSH_FRONT, '0, -32'sd1);
    send_op(ACT_REVERSE, '0, '0);
    send_op(ACT_POP_BACK, '0, '0);
  endtask

  task automatic test_index_limits();
    send_op(ACT_PUSH_BACK, '0, 32'sd11);
    send_op(ACT_PUSH_FRONT, '0, 32'sd22);
    send_op(ACT_INSERT, 7'd2, 32'sd33);
    send_op(ACT_INSERT, 7'd4, 32'sd44);
    send_op(ACT_READ, 7'd3, '0);
    send_op(ACT_READ, 7'd127, '0);
    send_op(ACT_REMOVE, 7'd1, '0);
    send_op(ACT_READ, 7'd1, '0);
    send_op(ACT_UNUSED_FIRST, '0, 32'sd1);
  endtask

  // Fill to capacity with random pushes and inserts, then hit the full checks.
  task automatic test_fill_to_capacity();
    int sel;
    while (shadow_q.size() < CAP) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) send_op(ACT_PUSH_BACK, pick_position(CAP), $urandom);
      else if (sel == 1) send_op(ACT_PUSH_FRONT, pick_position(CAP), $urandom);
      else send_op(ACT_INSERT, CNT_W'($urandom_range(0, shadow_q.size())), $urandom);
      random_sent++;
    end
    send_op(ACT_PUSH_BACK, '0, $urandom);
    send_op(ACT_PUSH_FRONT, '0, $urandom);
    send_op(ACT_INSERT, pick_position(2 * CAP), $urandom);
    send_op(ACT_READ, CNT_W'(CAP - 1), '0);
    send_op(ACT_READ, CNT_W'(CAP), '0);
    send_op(ACT_REVERSE, '0, '0);
    send_op(ACT_READ, '0, '0);
    random_sent += 7;
  endtask

  // Empty the store by pops and removes, then try taking from it.
  task automatic test_drain_to_empty();
    int sel;
    while (shadow_q.size() > 0) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) send_op(ACT_POP_BACK, pick_position(CAP), $urandom);
      else if (sel == 1) send_op(ACT_POP_FRONT, pick_position(CAP), $urandom);
      else if (sel == 2) send_op(ACT_READ, pick_position(shadow_q.size()), $urandom);
      else send_op(ACT_REMOVE, CNT_W'($urandom_range(0, shadow_q.size() - 1)), $urandom);
      random_sent++;
    end
    send_op(ACT_POP_FRONT, '0, '0);
    send_op(ACT_REMOVE, pick_position(4), '0);
    random_sent += 2;
  endtask

  task automatic test_random_mix(input int count);
    int r;
    logic [3:0] act;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 18) act = ACT_PUSH_BACK;
      else if (r < 30) act = ACT_PUSH_FRONT;
      else if (r < 40) act = ACT_POP_BACK;
      else if (r < 48) act = ACT_POP_FRONT;
      else if (r < 60) act = ACT_INSERT;
      else if (r < 75) act = ACT_READ;
      else if (r < 83) act = ACT_REMOVE;
      else if (r < 92) act = ACT_OVERWRITE;
      else if (r < 94) act = ACT_CLEAR;
      else if (r < 98) act = ACT_REVERSE;
      else act = 4'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      send_op(act, pick_position(shadow_q.size()), $urandom);
      if (act < ACT_UNUSED_FIRST) random_sent++;
    end
  endtask

  initial begin
    int guard;
    int kind;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_store();
    test_single_element();
    test_index_limits();

    while (random_sent < RANDOM_OPS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) test_fill_to_capacity();
      else if (kind == 1) test_drain_to_empty();
      else test_random_mix($urandom_range(10, 40));
    end

    // Leave the input idle and let the last results come out.
    in_valid <= 1'b0;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (expected_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_q.size()));

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/iss_pkg.sv
hw/rtl/iss_cell.sv
hw/rtl/iss_chain.sv
hw/rtl/indexed_sequence_store_core.sv
tb/tb_indexed_sequence_store_core.sv
